>>> sv/txc_pkg.sv
// Shared types, codes and constants of the text console glyph renderer.
package txc_pkg;

    localparam int FONT_BYTES_DEF   = 32768;
    localparam int MAX_GLYPH_WIDTH  = 32;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    typedef enum logic [2:0] {
        CFG_FORE,
        CFG_BACK,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_GCOLS,
        CFG_GROWS,
        CFG_SCOL,
        CFG_SROW
    } t_cfg_idx;

    typedef enum logic {
        CMD_FONT = 1'b0,
        CMD_CHAR = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_ROW    = 1'b0,
        KIND_SCROLL = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        OP_FONT,
        OP_SCROLL,
        OP_GLYPH
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_QUOT,
        B_REM,
        B_WRITE,
        B_SCROLL,
        B_ROWS
    } t_back_state;

    typedef struct packed {
        logic        cmd;
        logic [14:0] font_address;
        logic [7:0]  font_byte;
        logic [7:0]  character;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic [31:0] row_bits;
        logic [5:0]  row_length;
        logic [31:0] fore_value;
        logic [31:0] back_value;
        logic        last;
    } t_out_item;

    // One classified command from the front to the back.
    typedef struct packed {
        t_op         op;
        logic        scroll;
        logic [12:0] x;
        logic [12:0] y;
        logic [14:0] addr;
        logic [7:0]  data;
    } t_cmd_ent;

    // Glyph geometry and colours as the back uses them.
    typedef struct packed {
        logic [31:0] fore;
        logic [31:0] back;
        logic [5:0]  cols;
        logic [5:0]  rows;
        logic [2:0]  bpr;
    } t_glyph_cfg;

endpackage

>>> sv/txc_front.sv
// Front end: configuration registers, cursor tracking and command classification.
module txc_front
    import txc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd_ent   o_q_data,
    output t_glyph_cfg o_cfg
);

    function automatic logic [5:0] eff_dim(input logic [5:0] v, input int unsigned lim);
        if (v == 6'd0) return 6'd1;
        if (32'(v) > lim) return 6'(lim);
        return v;
    endfunction

    logic [31:0] r_fg, r_bg;
    logic [12:0] r_sw, r_sh;
    logic [5:0]  r_gc, r_gr;
    logic [11:0] r_sc;
    logic [12:0] r_cx, r_cy;
    logic [12:0] n_cx, n_cy;

    logic        accept;
    logic        cfg_we;
    logic [5:0]  gw, gh;
    logic [12:0] wrap_y, sat_y, gx, gy;
    logic        scr;
    t_cmd_ent    ent;

    assign gw          = eff_dim(r_gc, MAX_GLYPH_WIDTH);
    assign gh          = eff_dim(r_gr, MAX_GLYPH_HEIGHT);
    assign accept      = i_valid && !i_q_full;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;

    assign o_cfg.fore = r_fg;
    assign o_cfg.back = r_bg;
    assign o_cfg.cols = gw;
    assign o_cfg.rows = gh;
    assign o_cfg.bpr  = 3'((7'(gw) + 7'd7) >> 3);

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        ent      = '0;
        o_q_push = 1'b0;
        gx       = r_cx;
        gy       = r_cy;
        scr      = 1'b0;
        wrap_y   = r_cy + 13'(gh);
        sat_y    = (r_sh > 13'(gh)) ? (r_sh - 13'(gh)) : 13'd0;
        if (accept) begin
            if (i_data.cmd == CMD_FONT) begin
                o_q_push = 1'b1;
                ent.op   = OP_FONT;
                ent.addr = i_data.font_address;
                ent.data = i_data.font_byte;
            end else if (i_data.character == NEWLINE_CODE) begin
                n_cx = 13'(r_sc);
                n_cy = wrap_y;
                if (({1'b0, wrap_y} + 14'(gh)) > {1'b0, r_sh}) begin
                    o_q_push = 1'b1;
                    ent.op   = OP_SCROLL;
                    n_cy     = sat_y;
                end
            end else begin
                // Wrap first, then scroll if the glyph would pass the bottom.
                if (({1'b0, r_cx} + 14'(gw)) >= {1'b0, r_sw}) begin
                    gx = 13'(r_sc);
                    gy = wrap_y;
                end
                scr = ({1'b0, gy} + 14'(gh)) > {1'b0, r_sh};
                if (scr) begin
                    gx = 13'(r_sc);
                    gy = sat_y;
                end
                o_q_push   = 1'b1;
                ent.op     = OP_GLYPH;
                ent.scroll = scr;
                ent.x      = gx;
                ent.y      = gy;
                ent.data   = i_data.character;
                n_cx       = gx + 13'(gw);
                n_cy       = gy;
            end
        end
        if (cfg_we && (i_cfg_index == CFG_SCOL)) begin
            n_cx = 13'(i_cfg_data[11:0]);
        end
        if (cfg_we && (i_cfg_index == CFG_SROW)) begin
            n_cy = 13'(i_cfg_data[11:0]);
        end
    end

    assign o_q_data = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 32'hFFFF_FFFF;
            r_bg <= 32'd0;
            r_sw <= 13'd640;
            r_sh <= 13'd480;
            r_gc <= 6'd8;
            r_gr <= 6'd16;
            r_sc <= 12'd0;
            r_cx <= 13'd0;
            r_cy <= 13'd0;
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            if (cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FORE:   r_fg <= i_cfg_data;
                    CFG_BACK:   r_bg <= i_cfg_data;
                    CFG_WIDTH:  r_sw <= i_cfg_data[12:0];
                    CFG_HEIGHT: r_sh <= i_cfg_data[12:0];
                    CFG_GCOLS:  r_gc <= i_cfg_data[5:0];
                    CFG_GROWS:  r_gr <= i_cfg_data[5:0];
                    CFG_SCOL:   r_sc <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/txc_queue.sv
// Short command queue between the front end and the glyph back end.
module txc_queue
    import txc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd_ent i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_cmd_ent o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd_ent      r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic [PW:0]   n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign n_cnt   = r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
        end
    end

endmodule

>>> sv/txc_back.sv
// Back end: font store, glyph address reduction, row assembly and result buffer.
module txc_back
    import txc_pkg::*;
#(
    parameter int FONT_BYTES = FONT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_glyph_cfg i_cfg,
    input  logic       i_q_empty,
    input  t_cmd_ent   i_q_data,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_data
);

    localparam int AW      = $clog2(FONT_BYTES);
    localparam int MV_W    = 15;
    localparam int RECIP_W = 34 - $clog2(FONT_BYTES);
    localparam int PR_W    = MV_W + RECIP_W;
    localparam int Q_W     = PR_W - 32;
    // ceil(2^32 / FONT_BYTES): exact quotients for every 15-bit value.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << 32) + 64'(FONT_BYTES) - 64'd1) / 64'(FONT_BYTES));
    localparam logic [MV_W+1:0] F_EXT     = (MV_W+2)'(FONT_BYTES);
    localparam logic [AW-1:0]   ADDR_LAST = AW'(FONT_BYTES - 1);

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    logic [7:0] mem [FONT_BYTES];

    t_back_state     r_state, n_state;
    t_cmd_ent        r_cur;
    logic [MV_W-1:0] r_mv;
    logic [Q_W-1:0]  r_mq;
    logic [AW-1:0]   r_addr;
    logic [4:0]      r_row;
    logic [1:0]      r_byte;
    logic            r_rd_vld;
    logic [7:0]      r_rd_data;
    logic [1:0]      r_rd_byte;
    logic [4:0]      r_rd_row;
    logic [31:0]     r_acc;
    t_out_item       r_oq [2];
    logic            r_oq_wr, r_oq_rd;
    logic [1:0]      r_oq_cnt;

    logic            mem_we, issue, push_scroll, oq_pop, oq_push, room;
    logic            byte_last, row_last, row_done;
    logic [2:0]      occ;
    logic [7:0]      stride;
    logic [PR_W-1:0] recip_prod;
    logic [MV_W+1:0] rem_full;
    logic [31:0]     acc_next, col_mask;
    t_out_item       push_data;

    assign stride     = 8'(i_cfg.rows) * 8'(i_cfg.bpr);
    assign recip_prod = PR_W'(r_mv) * PR_W'(RECIP);
    assign rem_full   = {2'b00, r_mv} - ((MV_W+2)'(r_mq) * F_EXT);
    assign col_mask   = 32'((33'd1 << i_cfg.cols) - 33'd1);

    assign byte_last = ({1'b0, r_byte} == (i_cfg.bpr - 3'd1));
    assign row_last  = ({1'b0, r_row} == (i_cfg.rows - 6'd1));

    // A read is issued only when its row is sure to find a buffer slot.
    assign oq_pop = (r_oq_cnt != 2'd0) && !i_stall;
    assign occ    = 3'(r_oq_cnt) - 3'(oq_pop) + 3'(r_rd_vld);
    assign room   = (occ < 3'd2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty && !r_rd_vld) begin
                    n_state = (i_q_data.op == OP_SCROLL) ? B_SCROLL : B_MUL;
                end
            end
            B_MUL:  n_state = B_QUOT;
            B_QUOT: n_state = B_REM;
            B_REM: begin
                if (r_cur.op == OP_FONT) begin
                    n_state = B_WRITE;
                end else if (r_cur.scroll) begin
                    n_state = B_SCROLL;
                end else begin
                    n_state = B_ROWS;
                end
            end
            B_WRITE: n_state = B_IDLE;
            B_SCROLL: begin
                if (room && !r_rd_vld) begin
                    n_state = (r_cur.op == OP_SCROLL) ? B_IDLE : B_ROWS;
                end
            end
            B_ROWS: begin
                if (room && byte_last && row_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        issue       = 1'b0;
        push_scroll = 1'b0;
        case (r_state)
            B_IDLE:   o_q_pop     = !i_q_empty && !r_rd_vld;
            B_WRITE:  mem_we      = 1'b1;
            B_SCROLL: push_scroll = room && !r_rd_vld;
            B_ROWS:   issue       = room;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= r_cur.data;
        end
        if (issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Row assembly: each byte lands MSB first at its eight columns.
    assign acc_next = ((r_rd_byte == 2'd0) ? 32'd0 : r_acc)
                    | (32'(rev8(r_rd_data)) << {r_rd_byte, 3'b000});
    assign row_done = r_rd_vld && ({1'b0, r_rd_byte} == (i_cfg.bpr - 3'd1));
    assign oq_push  = row_done || push_scroll;

    always_comb begin
        push_data            = '0;
        push_data.row_length = i_cfg.cols;
        push_data.fore_value = i_cfg.fore;
        push_data.back_value = i_cfg.back;
        if (push_scroll) begin
            push_data.kind = KIND_SCROLL;
            push_data.last = (r_cur.op == OP_SCROLL);
        end else begin
            push_data.kind     = KIND_ROW;
            push_data.pixel_x  = r_cur.x;
            push_data.pixel_y  = r_cur.y + 13'(r_rd_row);
            push_data.row_bits = acc_next & col_mask;
            push_data.last     = ({1'b0, r_rd_row} == (i_cfg.rows - 6'd1));
        end
    end

    assign o_valid = (r_oq_cnt != 2'd0);
    assign o_data  = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        if (r_state == B_MUL) begin
            r_mv <= (r_cur.op == OP_FONT) ? r_cur.addr
                                          : (MV_W'(r_cur.data) * MV_W'(stride));
        end
        if (r_state == B_QUOT) begin
            r_mq <= recip_prod[PR_W-1:32];
        end
        if (r_state == B_REM) begin
            r_addr <= rem_full[AW-1:0];
            r_row  <= 5'd0;
            r_byte <= 2'd0;
        end
        if (issue) begin
            r_addr    <= (r_addr == ADDR_LAST) ? '0 : (r_addr + AW'(1));
            r_rd_byte <= r_byte;
            r_rd_row  <= r_row;
            if (byte_last) begin
                r_byte <= 2'd0;
                r_row  <= r_row + 5'd1;
            end else begin
                r_byte <= r_byte + 2'd1;
            end
        end
        if (r_rd_vld) begin
            r_acc <= acc_next;
        end
        if (oq_push) begin
            r_oq[r_oq_wr] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
            r_oq_wr  <= 1'b0;
            r_oq_rd  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_oq_cnt <= r_oq_cnt + 2'(oq_push) - 2'(oq_pop);
            if (oq_push) begin
                r_oq_wr <= !r_oq_wr;
            end
            if (oq_pop) begin
                r_oq_rd <= !r_oq_rd;
            end
        end
    end

endmodule

>>> sv/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer.
//
// Renders characters from a loadable bitmap font as a stream of pixel-row
// transactions for a framebuffer writer. The front end accepts one input
// transaction per cycle while its four-entry command queue has room; it
// updates the cursor at once, so a newline that needs no scroll produces
// nothing. The back end then works one command at a time from the single
// read port of the font store: a font byte load goes through pickup, address
// reduction (multiply, quotient, remainder) and write; a character reads
// glyph_rows * ceil(glyph_columns / 8) font bytes, after a scroll entry when
// it scrolls; a newline with scroll pushes only a scroll entry. Results wait
// in a two-entry buffer, so a stalled output holds up the font reads only
// once that buffer, counting a read in flight, is full. The font store has no
// reset or clearing pass; every glyph byte must be loaded before use.
module text_console_glyph_renderer
    import txc_pkg::*;
#(
    parameter int FONT_BYTES = FONT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic       q_push, q_pop, q_full, q_empty;
    t_cmd_ent   q_in, q_out;
    t_glyph_cfg glyph_cfg;

    txc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in),
        .o_cfg       (glyph_cfg)
    );

    txc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    txc_back #(
        .FONT_BYTES (FONT_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (glyph_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

>>> sv/txc_checker.sv
// Port-level checker for the text console glyph renderer and its bind.
module txc_checker
    import txc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    logic      out_acc;
    logic      r_have_prev;
    t_out_item r_prev;

    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (out_acc) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev <= o_data;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed or vanished while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // Rows of one glyph go down one line at a time at the same column.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_prev && !r_prev.last && (r_prev.kind == KIND_ROW)
        |-> (o_data.kind == KIND_ROW) && (o_data.pixel_x == r_prev.pixel_x)
            && (o_data.pixel_y == r_prev.pixel_y + 13'd1)
            && (o_data.row_length == r_prev.row_length)
            && (o_data.fore_value == r_prev.fore_value)
            && (o_data.back_value == r_prev.back_value))
        else $error("glyph rows out of sequence");

    // A scroll that does not end its transaction is followed by glyph rows.
    a_scroll_then_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_prev && !r_prev.last && (r_prev.kind == KIND_SCROLL)
        |-> (o_data.kind == KIND_ROW) && (o_data.row_length == r_prev.row_length))
        else $error("scroll not followed by a glyph row");

endmodule

bind text_console_glyph_renderer txc_checker u_txc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
